// ----- src/lbe_pkg.sv -----
// ============================================================================
// lbe_pkg: shared types and constants of the Legendre basis evaluator
// Holds the widths, the controller state encoding and the command and
// status bundles between controller and datapath.
// ============================================================================
`default_nettype none

package lbe_pkg;

    localparam int PT_W       = 32;   // Q16.16 point and bounds
    localparam int VAL_W      = 32;   // Q2.30 values
    localparam int DEG_W      = 5;
    localparam int NORM_W     = 6;
    localparam int ADDR_W     = 2;
    localparam int MAP_W      = PT_W + 2;            // exact difference of two Q16.16
    localparam int MAP_STEPS  = 32;                  // quotient bits of the mapping
    localparam int PROD_W     = 2 * VAL_W;
    localparam int T_W        = VAL_W + 2;           // rounded x*P, may reach 2^31
    localparam int NUM_W      = 40;                  // recurrence numerator
    localparam int DIV_BITS   = 4;                   // quotient bits per cycle
    localparam int DIV_STEPS  = NUM_W / DIV_BITS;
    localparam int CNT_W      = 6;
    localparam int TDATA_W    = 48;
    localparam int TUSER_W    = 2;

    localparam logic [DEG_W-1:0] MAX_ORDER = 5'd31;
    localparam logic signed [VAL_W-1:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    localparam logic [ADDR_W-1:0] REG_LOWER_BOUND = 2'd0;
    localparam logic [ADDR_W-1:0] REG_UPPER_BOUND = 2'd1;
    localparam logic [ADDR_W-1:0] REG_MAX_DEGREE  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_CHECK,
        ST_MAP_DIV,
        ST_MAP_FINISH,
        ST_EMIT,
        ST_MUL,
        ST_ROUND,
        ST_NUM,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DIV_FINISH
    } lbe_state_t;

    typedef struct packed {
        logic accept;
        logic map_check;
        logic map_step;
        logic map_finish;
        logic mul;
        logic round;
        logic num;
        logic div_load;
        logic div_step;
        logic div_finish;
        logic emit;
    } lbe_cmd_t;

    typedef struct packed {
        logic map_special;   // point lands on the upper bound or outside, or empty or reversed interval
        logic map_last;      // last mapping quotient bit
        logic div_last;      // last group of quotient bits
        logic deg_last;      // current degree is the highest requested
        logic deg_nonzero;   // next degree is two or more
    } lbe_status_t;

endpackage

`default_nettype wire

// ----- src/legendre_basis_evaluator_unit.sv -----
// ============================================================================
// legendre_basis_evaluator_unit: Legendre polynomial values per sample point
// Maps a Q16.16 point onto [-1,1] and streams P_0..P_N in Q2.30.
// ============================================================================
// One point is taken at a time. It is mapped onto [-1,1] by a restoring
// division, one quotient bit per cycle (skipped for points on the upper
// bound, outside the interval or with an empty or reversed interval), then
// N+1 results leave in degree order. Degrees 0 and 1 need no division; every
// higher degree is set mainly by the division by the degree, which retires
// 4 quotient bits a cycle over a 40-bit numerator. The next point is
// accepted once the last result of the current one sits in the output
// register.
// ============================================================================
`default_nettype none

module legendre_basis_evaluator_unit
    import lbe_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               cfg_we,
    input  wire logic [ADDR_W-1:0]  cfg_addr,
    input  wire logic [PT_W-1:0]    cfg_wdata,
    // input stream
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [PT_W-1:0]    s_axis_tdata,     // [31:0] point
    input  wire logic               s_axis_tlast,     // final_point
    // result stream
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,     // [4:0] degree, [36:5] poly_value,
                                                      // [42:37] norm_twice, rest zero
    output logic                    m_axis_tlast,     // last_of_point
    output logic [TUSER_W-1:0]      m_axis_tuser      // [0] set_done, [1] out_of_range
);

    logic [PT_W-1:0]   lower_bound_reg, upper_bound_reg;
    logic [DEG_W-1:0]  max_degree_reg;
    lbe_cmd_t          cmd;
    lbe_status_t       status;
    logic [DEG_W-1:0]  degree;
    logic [VAL_W-1:0]  poly_value;
    logic [NORM_W-1:0] norm_twice;
    logic              set_done, out_of_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_bound_reg <= 32'hFFFF_0000;
            upper_bound_reg <= 32'h0001_0000;
            max_degree_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_LOWER_BOUND: lower_bound_reg <= cfg_wdata;
                REG_UPPER_BOUND: upper_bound_reg <= cfg_wdata;
                REG_MAX_DEGREE:  max_degree_reg  <= cfg_wdata[DEG_W-1:0];
                default:         ;
            endcase
        end
    end

    lbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    lbe_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .point         (s_axis_tdata),
        .final_point   (s_axis_tlast),
        .lower_bound   (lower_bound_reg),
        .upper_bound   (upper_bound_reg),
        .max_degree    (max_degree_reg),
        .status        (status),
        .degree        (degree),
        .poly_value    (poly_value),
        .norm_twice    (norm_twice),
        .last_of_point (m_axis_tlast),
        .set_done      (set_done),
        .out_of_range  (out_of_range)
    );

    assign m_axis_tdata = {{(TDATA_W - NORM_W - VAL_W - DEG_W){1'b0}},
                           norm_twice, poly_value, degree};
    assign m_axis_tuser = {out_of_range, set_done};

endmodule

`default_nettype wire

// ----- src/lbe_ctrl.sv -----
// ============================================================================
// lbe_ctrl: sequencer of the Legendre basis evaluator
// Steps the datapath through the interval mapping and the per-degree
// recurrence and owns the output valid flag.
// ============================================================================
`default_nettype none

module lbe_ctrl
    import lbe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire lbe_status_t status,
    output lbe_cmd_t         cmd
);

    lbe_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_MAP_CHECK;
                end
            end
            ST_MAP_CHECK:
            begin
                cmd.map_check = 1'b1;
                state_next    = status.map_special ? ST_EMIT : ST_MAP_DIV;
            end
            ST_MAP_DIV:
            begin
                cmd.map_step = 1'b1;
                if (status.map_last)
                    state_next = ST_MAP_FINISH;
            end
            ST_MAP_FINISH:
            begin
                cmd.map_finish = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.deg_last)
                        state_next = ST_IDLE;
                    else if (status.deg_nonzero)
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                cmd.num    = 1'b1;
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_DIV_FINISH;
            end
            ST_DIV_FINISH:
            begin
                cmd.div_finish = 1'b1;
                state_next     = ST_EMIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

endmodule

`default_nettype wire

// ----- src/lbe_dpath.sv -----
// ============================================================================
// lbe_dpath: arithmetic of the Legendre basis evaluator
// Interval mapping by restoring division, one x*P multiply per degree from
// two on, the recurrence numerator and a radix-16 division by the degree.
// ============================================================================
`default_nettype none

module lbe_dpath
    import lbe_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lbe_cmd_t           cmd,
    input  wire logic [PT_W-1:0]    point,
    input  wire logic               final_point,
    input  wire logic [PT_W-1:0]    lower_bound,
    input  wire logic [PT_W-1:0]    upper_bound,
    input  wire logic [DEG_W-1:0]   max_degree,
    output lbe_status_t             status,
    output logic [DEG_W-1:0]        degree,
    output logic [VAL_W-1:0]        poly_value,
    output logic [NORM_W-1:0]       norm_twice,
    output logic                    last_of_point,
    output logic                    set_done,
    output logic                    out_of_range
);

    // point state
    logic signed [MAP_W-1:0]  span_reg;
    logic [MAP_W-1:0]         rem_reg;
    logic [MAP_STEPS-1:0]     q_reg;
    logic signed [VAL_W-1:0]  x_reg;
    logic                     oor_reg;
    logic                     fin_reg;
    logic [DEG_W-1:0]         n_reg;
    logic [DEG_W-1:0]         l_reg;
    logic [CNT_W-1:0]         cnt_reg;
    // recurrence state
    logic signed [VAL_W-1:0]  pm1_reg, pm2_reg, p_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [T_W-1:0]    t_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]         dq_reg;
    logic [DEG_W-1:0]         dr_reg;
    logic                     neg_reg;
    // output payload
    logic [DEG_W-1:0]         degree_reg;
    logic [VAL_W-1:0]         value_reg;
    logic [NORM_W-1:0]        norm_reg;
    logic                     last_reg, done_reg, oor_out_reg;

    // mapping
    logic signed [MAP_W-1:0]  lo_ext, hi_ext, pt_ext;
    logic                     span_nonpos, d_neg, d_gt, d_eq;
    logic [MAP_W-1:0]         rem_sh;
    logic                     rem_ge;
    logic [MAP_STEPS:0]       q_inc;
    logic [DEG_W-1:0]         n_clamped;

    // recurrence
    logic [PROD_W-1:0]        prod_mag;
    logic [PROD_W-1:0]        prod_rnd;
    logic [T_W-1:0]           t_mag;
    logic [NORM_W-1:0]        coef_a;
    logic [DEG_W-1:0]         coef_b;
    logic signed [T_W+NORM_W:0]  term_a;
    logic signed [VAL_W+DEG_W:0] term_b;
    logic signed [NUM_W-1:0]  num_next;
    logic [NUM_W-1:0]         num_mag;
    logic [NUM_W-1:0]         dq_next;
    logic [DEG_W-1:0]         dr_next;
    logic [DEG_W:0]           trial;
    logic signed [VAL_W-1:0]  p_next;
    logic signed [VAL_W-1:0]  emit_value;

    assign lo_ext = MAP_W'($signed(lower_bound));
    assign hi_ext = MAP_W'($signed(upper_bound));
    assign pt_ext = MAP_W'($signed(point));
    assign n_clamped = (max_degree > MAX_ORDER) ? MAX_ORDER : max_degree;

    // rem_reg holds the signed offset point - lower until the division starts
    assign span_nonpos = span_reg[MAP_W-1] || (span_reg == '0);
    assign d_neg       = rem_reg[MAP_W-1];
    assign d_gt        = $signed(rem_reg) > span_reg;
    assign d_eq        = $signed(rem_reg) == span_reg;

    assign rem_sh = {rem_reg[MAP_W-2:0], 1'b0};
    assign rem_ge = rem_sh >= $unsigned(span_reg);
    assign q_inc  = {1'b0, q_reg} + (MAP_STEPS+1)'(1);

    // round x*P to Q2.30, half away from zero
    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign prod_rnd = (prod_mag + (PROD_W'(1) << 29)) >> 30;
    assign t_mag    = prod_rnd[T_W-1:0];

    assign coef_a   = {l_reg, 1'b0} - NORM_W'(1);
    assign coef_b   = l_reg - DEG_W'(1);
    assign term_a   = t_reg * $signed({1'b0, coef_a});
    assign term_b   = pm2_reg * $signed({1'b0, coef_b});
    assign num_next = NUM_W'(term_a) - NUM_W'(term_b);
    assign num_mag  = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);

    // four restoring steps against the degree, remainder stays below it
    always_comb
    begin
        dq_next = dq_reg;
        dr_next = dr_reg;
        trial   = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial = {dr_next, dq_next[NUM_W-1]};
            if (trial >= {1'b0, l_reg})
            begin
                trial   = trial - {1'b0, l_reg};
                dq_next = {dq_next[NUM_W-2:0], 1'b1};
            end
            else
            begin
                dq_next = {dq_next[NUM_W-2:0], 1'b0};
            end
            dr_next = trial[DEG_W-1:0];
        end
    end

    always_comb
    begin
        if (neg_reg)
            p_next = (dq_reg > NUM_W'(33'h1_0000_0000 >> 1)) ? VAL_MIN
                                                           : VAL_W'(-dq_reg);
        else
            p_next = (dq_reg > NUM_W'(VAL_MAX)) ? VAL_MAX : VAL_W'(dq_reg);
    end

    always_comb
    begin
        if (l_reg == '0)
            emit_value = ONE_Q30;
        else if (l_reg == DEG_W'(1))
            emit_value = x_reg;
        else
            emit_value = p_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_reg   <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.accept || cmd.div_load)
                cnt_reg <= '0;
            else if (cmd.map_step || cmd.div_step)
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (cmd.accept)
                l_reg <= '0;
            else if (cmd.emit)
                l_reg <= l_reg + DEG_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            span_reg <= hi_ext - lo_ext;
            rem_reg  <= MAP_W'(pt_ext - lo_ext);
            q_reg    <= '0;
            fin_reg  <= final_point;
            n_reg    <= n_clamped;
            oor_reg  <= 1'b0;
        end
        if (cmd.map_check)
        begin
            oor_reg <= span_nonpos || d_neg || d_gt;
            x_reg   <= d_neg ? -ONE_Q30 : ONE_Q30;
        end
        if (cmd.map_step)
        begin
            rem_reg <= rem_ge ? rem_sh - $unsigned(span_reg) : rem_sh;
            q_reg   <= {q_reg[MAP_STEPS-2:0], rem_ge};
        end
        if (cmd.map_finish)
            x_reg <= $signed(q_inc[MAP_STEPS:1]) - ONE_Q30;
        if (cmd.mul)
            prod_reg <= x_reg * pm1_reg;
        if (cmd.round)
            t_reg <= prod_reg[PROD_W-1] ? -$signed(t_mag) : $signed(t_mag);
        if (cmd.num)
            num_reg <= num_next;
        if (cmd.div_load)
        begin
            neg_reg <= num_reg[NUM_W-1];
            dq_reg  <= num_mag + NUM_W'(l_reg >> 1);
            dr_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            dq_reg <= dq_next;
            dr_reg <= dr_next;
        end
        if (cmd.div_finish)
            p_reg <= p_next;
        if (cmd.emit)
        begin
            pm2_reg     <= pm1_reg;
            pm1_reg     <= emit_value;
            degree_reg  <= l_reg;
            value_reg   <= emit_value;
            norm_reg    <= {l_reg, 1'b1};
            last_reg    <= (l_reg == n_reg);
            done_reg    <= (l_reg == n_reg) && fin_reg;
            oor_out_reg <= oor_reg;
        end
    end

    assign status.map_special = span_nonpos || d_neg || d_gt || d_eq;
    assign status.map_last    = (cnt_reg == CNT_W'(MAP_STEPS - 1));
    assign status.div_last    = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign status.deg_last    = (l_reg == n_reg);
    assign status.deg_nonzero = (l_reg != '0);

    assign degree        = degree_reg;
    assign poly_value    = value_reg;
    assign norm_twice    = norm_reg;
    assign last_of_point = last_reg;
    assign set_done      = done_reg;
    assign out_of_range  = oor_out_reg;

endmodule

`default_nettype wire

// ----- dv/lbe_checker.sv -----
// ============================================================================
// lbe_checker: result predictor and comparator for the Legendre evaluator
// Follows configuration writes, works out P_0..P_N for every accepted point
// and compares each accepted result against the oldest pending term.
// ============================================================================

module lbe_checker
    import lbe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [ADDR_W-1:0]  cfg_addr,
    input  logic [PT_W-1:0]    cfg_wdata,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [PT_W-1:0]    s_axis_tdata,     // [31:0] point
    input  logic               s_axis_tlast,     // final_point
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [TDATA_W-1:0] m_axis_tdata,     // [4:0] degree, [36:5] poly_value,
                                                 // [42:37] norm_twice, rest zero
    input  logic               m_axis_tlast,     // last_of_point
    input  logic [TUSER_W-1:0] m_axis_tuser,     // [0] set_done, [1] out_of_range
    output int                 mismatches,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 30;
    localparam int PAD_LSB   = DEG_W + VAL_W + NORM_W;

    typedef struct {
        logic [DEG_W-1:0]         degree;
        logic signed [VAL_W-1:0]  value;
        logic [NORM_W-1:0]        norm;
        logic                     last;
        logic                     set_done;
        logic                     oor;
    } legendre_term_t;

    legendre_term_t pending_terms[$];

    logic signed [PT_W-1:0] lower_q16;
    logic signed [PT_W-1:0] upper_q16;
    logic [DEG_W-1:0]       top_degree;

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t ns  mismatch: %s", $realtime, msg);
    endtask

    function automatic longint round_q30(input longint v);
        longint unsigned mag;
        longint          r;
        mag = (v < 0) ? -v : v;
        r = longint'((mag + (64'd1 << 29)) >> 30);
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint div_nearest(input longint v, input longint d);
        longint unsigned mag;
        longint unsigned du;
        longint          r;
        mag = (v < 0) ? -v : v;
        du = d;
        r = longint'((mag + du / 2) / du);
        return (v < 0) ? -r : r;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_val(input longint v);
        if (v > longint'(VAL_MAX)) return VAL_MAX;
        if (v < longint'(VAL_MIN)) return VAL_MIN;
        return v[VAL_W-1:0];
    endfunction

    // Affine map onto [-1,1] in Q2.30; returns the saturation flag.
    function automatic bit map_to_unit(input logic signed [PT_W-1:0] pt_q16,
                                       output longint x);
        longint          p;
        longint          lo;
        longint          hi;
        longint          span;
        longint          d;
        longint unsigned rem;
        longint unsigned den;
        longint unsigned q;
        p = pt_q16;
        lo = lower_q16;
        hi = upper_q16;
        span = hi - lo;
        d = p - lo;
        if (span <= 0) begin
            x = (p < lo) ? -longint'(ONE_Q30) : longint'(ONE_Q30);
            return 1'b1;
        end
        if (d < 0) begin
            x = -longint'(ONE_Q30);
            return 1'b1;
        end
        if (d >= span) begin
            x = longint'(ONE_Q30);
            return d > span;
        end
        rem = d;
        den = span;
        q = 0;
        for (int i = 0; i < MAP_STEPS; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q = q | 1;
            end
        end
        q = (q + 1) >> 1;
        x = longint'(q) - longint'(ONE_Q30);
        return 1'b0;
    endfunction

    task automatic expand_legendre_terms(input logic [PT_W-1:0] pt, input logic fin);
        legendre_term_t term;
        longint         x;
        longint         prev1;
        longint         prev2;
        longint         p;
        longint         t;
        longint         num;
        bit             oor;
        int             n;
        oor = map_to_unit(pt, x);
        n = top_degree;
        if (n > MAX_ORDER) n = MAX_ORDER;
        prev1 = 0;
        prev2 = 0;
        for (int l = 0; l <= n; l++) begin
            if (l == 0)
                p = longint'(ONE_Q30);
            else if (l == 1)
                p = x;
            else begin
                // l*P_l = (2l-1)*x*P_(l-1) - (l-1)*P_(l-2)
                t = round_q30(x * prev1);
                num = longint'(2 * l - 1) * t - longint'(l - 1) * prev2;
                p = sat_val(div_nearest(num, l));
            end
            p = sat_val(p);
            term.degree   = l[DEG_W-1:0];
            term.value    = p[VAL_W-1:0];
            term.norm     = NORM_W'(2 * l + 1);
            term.last     = (l == n);
            term.set_done = (l == n) ? fin : 1'b0;
            term.oor      = oor;
            pending_terms.push_back(term);
            prev2 = prev1;
            prev1 = p;
        end
    endtask

    task automatic check_term();
        legendre_term_t          e;
        logic [DEG_W-1:0]        got_deg;
        logic signed [VAL_W-1:0] got_val;
        logic [NORM_W-1:0]       got_norm;
        got_deg  = m_axis_tdata[DEG_W-1:0];
        got_val  = m_axis_tdata[DEG_W +: VAL_W];
        got_norm = m_axis_tdata[DEG_W+VAL_W +: NORM_W];
        if (pending_terms.size() == 0) begin
            note_mismatch($sformatf("unexpected result, degree %0d value %0h",
                                    got_deg, got_val));
            return;
        end
        e = pending_terms.pop_front();
        if (got_deg !== e.degree)
            note_mismatch($sformatf("degree: got %0d want %0d", got_deg, e.degree));
        if (got_val !== e.value)
            note_mismatch($sformatf("poly_value at degree %0d: got %0h want %0h",
                                    e.degree, got_val, e.value));
        if (got_norm !== e.norm)
            note_mismatch($sformatf("norm_twice at degree %0d: got %0d want %0d",
                                    e.degree, got_norm, e.norm));
        if (m_axis_tdata[TDATA_W-1:PAD_LSB] !== '0)
            note_mismatch($sformatf("tdata padding at degree %0d not zero", e.degree));
        if (m_axis_tlast !== e.last)
            note_mismatch($sformatf("last_of_point at degree %0d: got %b want %b",
                                    e.degree, m_axis_tlast, e.last));
        if (m_axis_tuser[0] !== e.set_done)
            note_mismatch($sformatf("set_done at degree %0d: got %b want %b",
                                    e.degree, m_axis_tuser[0], e.set_done));
        if (m_axis_tuser[1] !== e.oor)
            note_mismatch($sformatf("out_of_range at degree %0d: got %b want %b",
                                    e.degree, m_axis_tuser[1], e.oor));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_q16 = 32'hFFFF_0000;
            upper_q16 = 32'h0001_0000;
            top_degree = '0;
            pending_terms.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            // results first: a point accepted on this edge cannot have one out yet
            if (m_axis_tvalid && m_axis_tready)
                check_term();
            if (s_axis_tvalid && s_axis_tready)
                expand_legendre_terms(s_axis_tdata, s_axis_tlast);
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_LOWER_BOUND: lower_q16 = cfg_wdata;
                    REG_UPPER_BOUND: upper_q16 = cfg_wdata;
                    REG_MAX_DEGREE:  top_degree = cfg_wdata[DEG_W-1:0];
                    default: ;
                endcase
            end
            outstanding = pending_terms.size();
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// ============================================================================
// tb_top: testbench of legendre_basis_evaluator_unit
// Directed points at the interval bounds, outside it and on empty or reversed
// intervals, then random settings and points with random idling on both
// streams and one long output hold-off; checking is done by lbe_checker.
// ============================================================================

module tb_top
    import lbe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_PCT        = 22;
    localparam int HOLD_CYCLES      = 1500;
    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int DRAIN_CYCLES     = 40;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RANDOM_PHASES    = 10;
    localparam int POINTS_PER_PHASE = 28;
    localparam int QUIET_PHASE      = 3;
    localparam int HOLD_PHASE       = 5;

    // no register behind this index; writes must be dropped
    localparam logic [ADDR_W-1:0] REG_UNMAPPED = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [ADDR_W-1:0]  cfg_addr;
    logic [PT_W-1:0]    cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [PT_W-1:0]    s_axis_tdata;     // [31:0] point
    logic               s_axis_tlast;     // final_point
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;     // [4:0] degree, [36:5] poly_value,
                                          // [42:37] norm_twice, rest zero
    logic               m_axis_tlast;     // last_of_point
    logic [TUSER_W-1:0] m_axis_tuser;     // [0] set_done, [1] out_of_range

    int mismatches;
    int outstanding;

    bit src_idle_en;
    bit sink_idle_en;
    int hold_left;
    int quiet_cycles;

    logic signed [PT_W-1:0] cur_lo;
    logic signed [PT_W-1:0] cur_hi;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    legendre_basis_evaluator_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    lbe_checker legendre_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // result sink: long hold-off when requested, else random stalls
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else if (sink_idle_en)
                m_axis_tready = ($urandom_range(0, 99) >= STALL_PCT);
            else
                m_axis_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [PT_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // wait until every pending result has been taken and the unit is quiet
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_setting(input logic [PT_W-1:0] lo, input logic [PT_W-1:0] hi,
                                 input logic [DEG_W-1:0] n);
        logic [PT_W-1:0] deg_word;
        settle();
        deg_word = $urandom;        // upper bits are don't-care
        deg_word[DEG_W-1:0] = n;
        write_reg(REG_LOWER_BOUND, lo);
        write_reg(REG_UPPER_BOUND, hi);
        write_reg(REG_MAX_DEGREE, deg_word);
        cur_lo = lo;
        cur_hi = hi;
    endtask

    task automatic send_point(input logic [PT_W-1:0] pt, input logic fin);
        @(negedge clk);
        while (src_idle_en && $urandom_range(0, 99) < STALL_PCT)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = pt;
        s_axis_tlast = fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic logic [PT_W-1:0] pick_point();
        longint          lo;
        longint          hi;
        longint unsigned r;
        lo = cur_lo;
        hi = cur_hi;
        case ($urandom_range(0, 9))
            0: return cur_lo;
            1: return cur_hi;
            2, 3: return $urandom;
            4: return cur_lo - 1;
            5: return cur_hi + 1;
            default:
            begin
                if (hi <= lo)
                    return $urandom;
                r = {$urandom, $urandom};
                return PT_W'(lo + longint'(r % longint'(hi - lo + 1)));
            end
        endcase
    endfunction

    task automatic random_setting(input int phase);
        logic [PT_W-1:0]   lo;
        logic [PT_W-1:0]   hi;
        logic [DEG_W-1:0]  n;
        longint            top;
        int unsigned       k;
        lo = $urandom;
        case ($urandom_range(0, 5))
            0:
            begin
                top = longint'($signed(lo)) + $urandom_range(1, 32'h0004_0000);
                hi = (top > 64'sh7FFF_FFFF) ? 32'h7FFF_FFFF : PT_W'(top);
            end
            1:
            begin
                lo = 32'h8000_0000;
                hi = 32'h7FFF_FFFF;
            end
            2: hi = $urandom;
            3: hi = lo;
            4:
            begin
                k = $urandom_range(1, 32'h7FFF_FFFF);
                lo = -k;
                hi = k;
            end
            default:
            begin
                // spans of a few LSBs stress the rounding of the map
                top = longint'($signed(lo)) + $urandom_range(1, 3);
                hi = (top > 64'sh7FFF_FFFF) ? 32'h7FFF_FFFF : PT_W'(top);
            end
        endcase
        if ($urandom_range(0, 3) == 0)
            n = $urandom_range(0, 31);
        else
            n = $urandom_range(0, 8);
        if (phase == 0)
            n = MAX_ORDER;
        else if (phase == 1)
            n = '0;
        apply_setting(lo, hi, n);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        hold_left = 0;
        cur_lo = 32'hFFFF_0000;
        cur_hi = 32'h0001_0000;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // reset setting: [-1,1], degree 0 only
        send_point(32'h0000_0000, 1'b0);
        send_point(32'hFFFF_0000, 1'b1);

        settle();
        write_reg(REG_UNMAPPED, 32'hDEAD_BEEF);
        apply_setting(32'hFFFF_0000, 32'h0001_0000, MAX_ORDER);
        send_point(32'hFFFF_0000, 1'b0);   // on lower bound
        send_point(32'h0001_0000, 1'b0);   // on upper bound, not flagged
        send_point(32'h0000_8000, 1'b0);
        send_point(32'h8000_0000, 1'b1);   // below
        send_point(32'h7FFF_FFFF, 1'b0);   // above
        send_point(32'h0000_5555, 1'b0);

        // widest interval
        apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 5'd7);
        send_point(32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 1'b0);
        send_point(32'h0000_0000, 1'b0);
        send_point(32'hFFFF_FFFF, 1'b0);
        send_point(32'h0000_0001, 1'b1);

        // empty interval
        apply_setting(32'h0003_0000, 32'h0003_0000, 5'd2);
        send_point(32'h0002_0000, 1'b0);
        send_point(32'h0003_0000, 1'b0);
        send_point(32'h0004_0000, 1'b1);

        // reversed interval at the extremes
        apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 5'd1);
        send_point(32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 1'b0);
        send_point(32'h0000_0000, 1'b1);

        // one-LSB span
        apply_setting(32'h0000_0000, 32'h0000_0001, 5'd4);
        send_point(32'h0000_0000, 1'b0);
        send_point(32'h0000_0001, 1'b1);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            random_setting(phase);
            @(posedge clk);
            src_idle_en = (phase != QUIET_PHASE);
            sink_idle_en = (phase != QUIET_PHASE);
            // output held off while points keep coming: input must back up
            if (phase == HOLD_PHASE)
                hold_left = HOLD_CYCLES;
            repeat (POINTS_PER_PHASE)
                send_point(pick_point(), ($urandom_range(0, 7) == 0));
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
